/* rtl/vrq_pkg.sv */
`default_nettype none

package vrq_pkg;

	// Fixed field widths of the request and response payloads
	localparam int KEY_BITS    = 32;
	localparam int HANDLE_BITS = 8;
	localparam int MODE_BITS   = 2;
	localparam int STATUS_BITS = 2;
	localparam int COUNT_BITS  = 5;

	localparam int QUEUE_DEPTH_DEF = 16;

	typedef enum logic [MODE_BITS-1:0] {
		MODE_INSERT = 2'd0,
		MODE_POP    = 2'd1,
		MODE_REMOVE = 2'd2
	} mode_t;

	typedef enum logic [STATUS_BITS-1:0] {
		STATUS_OK        = 2'd0,
		STATUS_EMPTY     = 2'd1,
		STATUS_NOT_FOUND = 2'd2,
		STATUS_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		logic [KEY_BITS-1:0]    key;
		logic [HANDLE_BITS-1:0] handle;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_RESP
	} state_t;

endpackage

`default_nettype wire

/* rtl/vrq_req_if.sv */
`default_nettype none

interface vrq_req_if;
	logic                            valid;
	logic                            ready;
	logic [vrq_pkg::MODE_BITS-1:0]   mode;
	logic [vrq_pkg::HANDLE_BITS-1:0] task_handle;
	logic [vrq_pkg::KEY_BITS-1:0]    run_key;

	modport source (output valid, output mode, output task_handle, output run_key,
		input ready);
	modport sink (input valid, input mode, input task_handle, input run_key,
		output ready);
endinterface

`default_nettype wire

/* rtl/vrq_rsp_if.sv */
`default_nettype none

interface vrq_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [vrq_pkg::STATUS_BITS-1:0] status;
	logic [vrq_pkg::HANDLE_BITS-1:0] out_handle;
	logic [vrq_pkg::KEY_BITS-1:0]    out_key;
	logic [vrq_pkg::COUNT_BITS-1:0]  entry_count;

	modport source (output valid, output status, output out_handle, output out_key,
		output entry_count, input ready);
	modport sink (input valid, input status, input out_handle, input out_key,
		input entry_count, output ready);
endinterface

`default_nettype wire

/* rtl/vruntime_ordered_run_queue.sv */
`default_nettype none

// Channel | Dir | Payload                                    | Transaction
// --------+-----+--------------------------------------------+---------------------
// req     | in  | mode, task_handle, run_key                 | valid & ready at clk
// rsp     | out | status, out_handle, out_key, entry_count   | valid & ready at clk
//
// One request at a time, with N entries stored. The entry store has a single
// registered read port, so each entry visited takes a read step and then a
// compare/write step. Insert walks down from the top slot, moving entries up
// until a smaller key or the head is reached; pop and remove visit every stored
// entry from slot zero; refused or trivial requests go straight to the response.
// arst_n clears the state machine, the entry count and the response valid flag;
// the entry store is not cleared, as only entries below the count are ever read.
// A stalled rsp holds its register; the next request is taken meanwhile and
// waits in the response state until the register frees.

module vruntime_ordered_run_queue #(
	parameter int QUEUE_DEPTH = vrq_pkg::QUEUE_DEPTH_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	vrq_req_if.sink    req,
	vrq_rsp_if.source  rsp
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Sequencer state
	vrq_pkg::state_t                 state_q, state_d;
	logic [CNT_W-1:0]                count_q;
	logic [IDX_W-1:0]                idx_q;
	logic                            found_q;
	logic                            is_pop_q;
	logic [vrq_pkg::KEY_BITS-1:0]    key_q;
	logic [vrq_pkg::HANDLE_BITS-1:0] handle_q;
	vrq_pkg::status_t                res_status_q;
	logic [vrq_pkg::HANDLE_BITS-1:0] res_handle_q;
	logic [vrq_pkg::KEY_BITS-1:0]    res_key_q;

	// Response register
	logic                            out_valid_q;
	vrq_pkg::status_t                out_status_q;
	logic [vrq_pkg::HANDLE_BITS-1:0] out_handle_q;
	logic [vrq_pkg::KEY_BITS-1:0]    out_key_q;
	logic [CNT_W-1:0]                out_count_q;

	// Entry store
	vrq_pkg::entry_t                 mem_q [QUEUE_DEPTH];
	vrq_pkg::entry_t                 rd_q;
	logic                            mem_we;
	logic [IDX_W-1:0]                mem_wa;
	vrq_pkg::entry_t                 mem_wd;
	logic [IDX_W-1:0]                mem_ra;

	logic                            accept;
	logic                            out_free;
	logic                            full;
	logic                            empty;
	logic                            ins_lt;
	logic                            scan_hit;
	logic                            scan_last;
	logic                            ins_done;

	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	// New entry goes above the stored one only while the stored key is smaller
	assign ins_lt    = (rd_q.key < key_q);
	assign scan_hit  = is_pop_q || (rd_q.handle == handle_q);
	assign scan_last = (idx_q == IDX_W'(count_q - 1'b1));
	assign ins_done  = ((state_q == vrq_pkg::ST_INS_RD) && (idx_q == '0)) ||
		((state_q == vrq_pkg::ST_INS_CMP) && ins_lt);

	assign req.ready = (state_q == vrq_pkg::ST_IDLE);

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.out_handle  = out_handle_q;
	assign rsp.out_key     = out_key_q;
	assign rsp.entry_count = vrq_pkg::COUNT_BITS'(out_count_q);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vrq_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (req.mode) inside
						vrq_pkg::MODE_INSERT:
							state_d = full ? vrq_pkg::ST_RESP : vrq_pkg::ST_INS_RD;
						vrq_pkg::MODE_POP, vrq_pkg::MODE_REMOVE:
							state_d = empty ? vrq_pkg::ST_RESP : vrq_pkg::ST_SCAN_RD;
						default:
							state_d = vrq_pkg::ST_RESP;
					endcase
				end
			end
			vrq_pkg::ST_INS_RD:
				state_d = (idx_q == '0) ? vrq_pkg::ST_RESP : vrq_pkg::ST_INS_CMP;
			vrq_pkg::ST_INS_CMP:
				state_d = ins_lt ? vrq_pkg::ST_RESP : vrq_pkg::ST_INS_RD;
			vrq_pkg::ST_SCAN_RD:
				state_d = vrq_pkg::ST_SCAN_CMP;
			vrq_pkg::ST_SCAN_CMP:
				state_d = scan_last ? vrq_pkg::ST_RESP : vrq_pkg::ST_SCAN_RD;
			vrq_pkg::ST_RESP:
				state_d = out_free ? vrq_pkg::ST_IDLE : vrq_pkg::ST_RESP;
			default:
				state_d = vrq_pkg::ST_IDLE;
		endcase
	end

	// Store port controls
	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_q;
		mem_wd = rd_q;
		mem_ra = idx_q;
		unique case (state_q)
			vrq_pkg::ST_INS_RD: begin
				// Slot zero reached: drop the new entry in at the head
				if (idx_q == '0) begin
					mem_we = 1'b1;
					mem_wd = '{key: key_q, handle: handle_q};
				end else begin
					mem_ra = idx_q - 1'b1;
				end
			end
			vrq_pkg::ST_INS_CMP: begin
				// Either place the new entry here or move the stored one up a slot
				mem_we = 1'b1;
				if (ins_lt) begin
					mem_wd = '{key: key_q, handle: handle_q};
				end
			end
			vrq_pkg::ST_SCAN_CMP: begin
				// Past the deleted entry: close the gap by moving each entry down
				if (found_q) begin
					mem_we = 1'b1;
					mem_wa = idx_q - 1'b1;
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		rd_q <= mem_q[mem_ra];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= vrq_pkg::ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ins_done) begin
				count_q <= count_q + 1'b1;
			end else if ((state_q == vrq_pkg::ST_SCAN_CMP) && scan_last &&
					(found_q || scan_hit)) begin
				count_q <= count_q - 1'b1;
			end
			if ((state_q == vrq_pkg::ST_RESP) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working and response payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			vrq_pkg::ST_IDLE: begin
				if (accept) begin
					key_q        <= req.run_key;
					handle_q     <= req.task_handle;
					is_pop_q     <= (req.mode == vrq_pkg::MODE_POP);
					found_q      <= 1'b0;
					res_handle_q <= '0;
					res_key_q    <= '0;
					idx_q        <= (req.mode == vrq_pkg::MODE_INSERT) ?
						IDX_W'(count_q) : '0;
					unique case (req.mode)
						vrq_pkg::MODE_INSERT:
							res_status_q <= full ? vrq_pkg::STATUS_FULL : vrq_pkg::STATUS_OK;
						vrq_pkg::MODE_POP:
							res_status_q <= empty ? vrq_pkg::STATUS_EMPTY : vrq_pkg::STATUS_OK;
						vrq_pkg::MODE_REMOVE:
							res_status_q <= empty ? vrq_pkg::STATUS_NOT_FOUND :
								vrq_pkg::STATUS_OK;
						default:
							res_status_q <= vrq_pkg::STATUS_OK;
					endcase
				end
			end
			vrq_pkg::ST_INS_CMP: begin
				if (!ins_lt) begin
					idx_q <= idx_q - 1'b1;
				end
			end
			vrq_pkg::ST_SCAN_CMP: begin
				if (!found_q && scan_hit) begin
					found_q <= 1'b1;
					if (is_pop_q) begin
						res_handle_q <= rd_q.handle;
						res_key_q    <= rd_q.key;
					end
				end
				if (scan_last) begin
					res_status_q <= (found_q || scan_hit) ? vrq_pkg::STATUS_OK :
						vrq_pkg::STATUS_NOT_FOUND;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			vrq_pkg::ST_RESP: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_handle_q <= res_handle_q;
					out_key_q    <= res_key_q;
					out_count_q  <= count_q;
				end
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	// Checks

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count beyond queue depth");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ins_done |=> (count_q == $past(count_q) + 1'b1))
		else $error("finished insert did not grow the count by one");

	a_full_refusal: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_status_q == vrq_pkg::STATUS_FULL)) |->
		(out_count_q == CNT_W'(QUEUE_DEPTH)))
		else $error("full status reported below queue depth");

	a_empty_pop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_status_q == vrq_pkg::STATUS_EMPTY)) |->
		((out_handle_q == '0) && (out_key_q == '0) && (out_count_q == '0)))
		else $error("empty pop carried an entry");

endmodule

`default_nettype wire
